FILE: hw/rtl/bmff_pkg.sv
// Shared constants, codes and control types of the bit table with find-first.
`timescale 1ns / 1ps

package bmff_pkg;

   localparam int MAX_BITS   = 1024;
   localparam int WORD_BITS  = 32;
   localparam int WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_AW    = $clog2(WORD_COUNT);
   localparam int OFF_W      = $clog2(WORD_BITS);
   localparam int POS_W      = 10;
   localparam int CNT_W      = 11;
   localparam int VAL_W      = 8;
   localparam int CODE_W     = 3;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;

   localparam logic [CNT_W-1:0]     BIT_COUNT_RESET = CNT_W'(MAX_BITS);
   localparam logic [WORD_BITS-1:0] TOP_BIT         = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic [WORD_BITS-1:0] ALL_ONES        = {WORD_BITS{1'b1}};

   // register index of bit_count, taken from paddr[2]
   localparam logic REG_BIT_COUNT = 1'b0;

   typedef enum logic [CODE_W-1:0] {
      REQ_READ  = 3'd0,
      REQ_WRITE = 3'd1,
      REQ_FILL  = 3'd2,
      REQ_TEST  = 3'd3,
      REQ_FIND  = 3'd4
   } req_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_WRITE,
      ST_FILL,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic mem_rd;
      logic idx_step;
      logic latch_bit;
      logic write_bit;
      logic fill_word;
      logic scan_eval;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [CODE_W-1:0] req_code;
      logic              bad;
      logic              val_ok;
      logic              n_zero;
      logic              idx_last;
      logic              scan_stop;
      logic              rsp_pending;
   } dp_status_type;

endpackage

FILE: hw/rtl/bmff_csr.sv
// Configuration register file: bit_count behind an APB-style port.
`timescale 1ns / 1ps

module bmff_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [bmff_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [bmff_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [bmff_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready,
   output logic [bmff_pkg::CNT_W-1:0]    bit_count
);

   logic [bmff_pkg::CNT_W-1:0] bit_count_ff;
   logic [bmff_pkg::CNT_W-1:0] bit_count_in;
   logic                       hit_count;

   assign hit_count = (csr_paddr[2] == bmff_pkg::REG_BIT_COUNT);

   always_comb begin
      bit_count_in = bit_count_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit_count) begin
         bit_count_in = csr_pwdata[bmff_pkg::CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff <= bmff_pkg::BIT_COUNT_RESET;
      end else begin
         bit_count_ff <= bit_count_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = hit_count ?
                       {{(bmff_pkg::CSR_DW-bmff_pkg::CNT_W){1'b0}}, bit_count_ff} : '0;
   assign bit_count  = bit_count_ff;

endmodule

FILE: hw/rtl/bmff_ctrl.sv
// Request sequencer: decodes a request and steps the datapath through it.
`timescale 1ns / 1ps

module bmff_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bmff_pkg::dp_status_type status,
   output bmff_pkg::ctrl_cmd_type  cmd
);

   bmff_pkg::state_type state_ff;
   bmff_pkg::state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bmff_pkg::ST_IDLE: begin
            if (req_valid) state_in = bmff_pkg::ST_DECODE;
         end
         bmff_pkg::ST_DECODE: begin
            unique case (status.req_code)
               bmff_pkg::REQ_READ:
                  state_in = status.bad ? bmff_pkg::ST_DONE : bmff_pkg::ST_READ;
               bmff_pkg::REQ_WRITE:
                  state_in = status.bad ? bmff_pkg::ST_DONE : bmff_pkg::ST_WRITE;
               bmff_pkg::REQ_FILL:
                  state_in = (status.val_ok && !status.n_zero) ?
                             bmff_pkg::ST_FILL : bmff_pkg::ST_DONE;
               bmff_pkg::REQ_TEST:
                  state_in = (status.val_ok && !status.n_zero) ?
                             bmff_pkg::ST_SCAN : bmff_pkg::ST_DONE;
               bmff_pkg::REQ_FIND:
                  state_in = (status.val_ok && !status.bad) ?
                             bmff_pkg::ST_SCAN : bmff_pkg::ST_DONE;
               default:
                  state_in = bmff_pkg::ST_DONE;
            endcase
         end
         bmff_pkg::ST_READ:  state_in = bmff_pkg::ST_DONE;
         bmff_pkg::ST_WRITE: state_in = bmff_pkg::ST_DONE;
         bmff_pkg::ST_FILL: begin
            if (status.idx_last) state_in = bmff_pkg::ST_DONE;
         end
         bmff_pkg::ST_SCAN: begin
            if (status.scan_stop) state_in = bmff_pkg::ST_DONE;
         end
         bmff_pkg::ST_DONE: begin
            if (!status.rsp_pending) state_in = bmff_pkg::ST_IDLE;
         end
         default: state_in = bmff_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         bmff_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         bmff_pkg::ST_DECODE: begin
            unique case (status.req_code)
               bmff_pkg::REQ_READ,
               bmff_pkg::REQ_WRITE: begin
                  cmd.mem_rd = !status.bad;
               end
               bmff_pkg::REQ_TEST: begin
                  cmd.mem_rd   = status.val_ok && !status.n_zero;
                  cmd.idx_step = status.val_ok && !status.n_zero;
               end
               bmff_pkg::REQ_FIND: begin
                  cmd.mem_rd   = status.val_ok && !status.bad;
                  cmd.idx_step = status.val_ok && !status.bad;
               end
               default: ;
            endcase
         end
         bmff_pkg::ST_READ:  cmd.latch_bit = 1'b1;
         bmff_pkg::ST_WRITE: cmd.write_bit = 1'b1;
         bmff_pkg::ST_FILL: begin
            cmd.fill_word = 1'b1;
            cmd.idx_step  = 1'b1;
         end
         bmff_pkg::ST_SCAN: begin
            cmd.scan_eval = 1'b1;
            cmd.mem_rd    = 1'b1;
            cmd.idx_step  = 1'b1;
         end
         bmff_pkg::ST_DONE: cmd.load_rsp = !status.rsp_pending;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bmff_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/bmff_dpath.sv
// Datapath: word memory, request registers, scan logic and result register.
`timescale 1ns / 1ps

module bmff_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [bmff_pkg::CODE_W-1:0]   req_type,
   input  logic [bmff_pkg::POS_W-1:0]    req_position,
   input  logic [bmff_pkg::VAL_W-1:0]    req_value,
   input  logic [bmff_pkg::CNT_W-1:0]    bit_count,
   input  bmff_pkg::ctrl_cmd_type        cmd,
   output bmff_pkg::dp_status_type       status,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic                          rsp_bit_value,
   output logic                          rsp_found,
   output logic [bmff_pkg::POS_W-1:0]    rsp_found_position,
   output logic                          rsp_all_equal,
   output logic                          rsp_bad_position
);

   localparam int WB = bmff_pkg::WORD_BITS;
   localparam int AW = bmff_pkg::WORD_AW;
   localparam int OW = bmff_pkg::OFF_W;

   function automatic logic [4:0] first_set(input logic [31:0] x);
      logic [31:0] v;
      logic [4:0]  c;
      v = x;
      c = '0;
      if (v[31:16] == '0) begin c[4] = 1'b1; v = v << 16; end
      if (v[31:24] == '0) begin c[3] = 1'b1; v = v << 8;  end
      if (v[31:28] == '0) begin c[2] = 1'b1; v = v << 4;  end
      if (v[31:30] == '0) begin c[1] = 1'b1; v = v << 2;  end
      if (!v[31])         begin c[0] = 1'b1;              end
      return c;
   endfunction

   logic [WB-1:0] mem [bmff_pkg::WORD_COUNT];
   logic [bmff_pkg::WORD_COUNT-1:0] valid_ff;

   logic [bmff_pkg::CODE_W-1:0] code_ff;
   logic [bmff_pkg::POS_W-1:0]  pos_ff;
   logic [bmff_pkg::VAL_W-1:0]  val_ff;
   logic [bmff_pkg::CNT_W-1:0]  n_ff, n_in, n_m1;
   logic [AW-1:0]               last_ff;
   logic [OW-1:0]               tail_ff;
   logic [AW-1:0]               idx_ff, idx_in, idx_start;
   logic [AW-1:0]               ev_idx_ff;
   logic [WB-1:0]               rd_word_ff;
   logic                        rd_vld_ff;
   logic                        bit_ff;
   logic                        hit_ff;
   logic [bmff_pkg::POS_W-1:0]  hit_pos_ff;

   logic                        rsp_valid_ff;
   logic                        rsp_bit_ff, rsp_found_ff, rsp_all_ff, rsp_bad_ff;
   logic [bmff_pkg::POS_W-1:0]  rsp_fpos_ff;
   logic                        rsp_bit_in, rsp_found_in, rsp_all_in, rsp_bad_in;
   logic [bmff_pkg::POS_W-1:0]  rsp_fpos_in;

   logic [WB-1:0] word, pattern, use_mask, start_mask, hit_bits, bit_mask, wr_data_in;
   logic [OW-1:0] pos_off, hit_off;
   logic          bad, val_ok, n_zero, word_hit, ev_last;
   logic          is_read, is_write, is_test, is_find;

   // effective count and its word geometry
   always_comb begin
      n_in = (bit_count > bmff_pkg::CNT_W'(bmff_pkg::MAX_BITS)) ?
             bmff_pkg::CNT_W'(bmff_pkg::MAX_BITS) : bit_count;
      n_m1 = n_in - bmff_pkg::CNT_W'(1);
      idx_start = ((req_type == bmff_pkg::REQ_FILL) || (req_type == bmff_pkg::REQ_TEST)) ?
                  '0 : req_position[OW +: AW];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         code_ff <= req_type;
         pos_ff  <= req_position;
         val_ff  <= req_value;
         n_ff    <= n_in;
         last_ff <= n_m1[OW +: AW];
         tail_ff <= n_in[OW-1:0];
      end
   end

   assign is_read  = (code_ff == bmff_pkg::REQ_READ);
   assign is_write = (code_ff == bmff_pkg::REQ_WRITE);
   assign is_test  = (code_ff == bmff_pkg::REQ_TEST);
   assign is_find  = (code_ff == bmff_pkg::REQ_FIND);

   assign bad     = ({1'b0, pos_ff} >= n_ff);
   assign val_ok  = (val_ff[bmff_pkg::VAL_W-1:1] == '0);
   assign n_zero  = (n_ff == '0);
   assign pos_off = pos_ff[OW-1:0];

   // word walk
   always_comb begin
      idx_in = idx_ff;
      if (cmd.capture) begin
         idx_in = idx_start;
      end else if (cmd.idx_step) begin
         idx_in = idx_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.mem_rd) begin
         rd_word_ff <= mem[idx_ff];
         rd_vld_ff  <= valid_ff[idx_ff];
         ev_idx_ff  <= idx_ff;
      end
   end

   // word just read, masked to the bits that take part
   always_comb begin
      word       = rd_vld_ff ? rd_word_ff : '0;
      pattern    = {WB{val_ff[0]}};
      ev_last    = (ev_idx_ff == last_ff);
      use_mask   = (ev_last && (tail_ff != '0)) ? ~(bmff_pkg::ALL_ONES >> tail_ff) :
                   bmff_pkg::ALL_ONES;
      start_mask = (is_find && (ev_idx_ff == pos_ff[OW +: AW])) ?
                   (bmff_pkg::ALL_ONES >> pos_off) : bmff_pkg::ALL_ONES;
      hit_bits   = is_find ? (~(word ^ pattern) & use_mask & start_mask) :
                             ((word ^ pattern) & use_mask);
      word_hit   = |hit_bits;
      hit_off    = first_set(hit_bits);
      bit_mask   = bmff_pkg::TOP_BIT >> pos_off;
      if (cmd.fill_word) begin
         wr_data_in = pattern;
      end else if (val_ff == bmff_pkg::VAL_W'(0)) begin
         wr_data_in = word & ~bit_mask;
      end else if (val_ff == bmff_pkg::VAL_W'(1)) begin
         wr_data_in = word | bit_mask;
      end else begin
         wr_data_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_bit || cmd.fill_word) begin
         mem[idx_ff] <= wr_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.write_bit || cmd.fill_word) begin
         valid_ff[idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_bit) begin
         bit_ff <= word[OW'(WB-1) - pos_off];
      end
      if (cmd.capture) begin
         hit_ff <= 1'b0;
      end else if (cmd.scan_eval && word_hit) begin
         hit_ff     <= 1'b1;
         hit_pos_ff <= {ev_idx_ff, hit_off};
      end
   end

   // result register
   always_comb begin
      rsp_bad_in   = (is_read || is_write || is_find) && bad;
      rsp_bit_in   = is_read && !bad && bit_ff;
      rsp_found_in = is_find && !bad && val_ok && hit_ff;
      rsp_fpos_in  = rsp_found_in ? hit_pos_ff : '0;
      rsp_all_in   = is_test && (n_zero || (val_ok && !hit_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_bit_ff   <= rsp_bit_in;
         rsp_found_ff <= rsp_found_in;
         rsp_fpos_ff  <= rsp_fpos_in;
         rsp_all_ff   <= rsp_all_in;
         rsp_bad_ff   <= rsp_bad_in;
      end
   end

   always_comb begin
      status.req_code    = code_ff;
      status.bad         = bad;
      status.val_ok      = val_ok;
      status.n_zero      = n_zero;
      status.idx_last    = (idx_ff == last_ff);
      status.scan_stop   = word_hit || ev_last;
      status.rsp_pending = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_bit_value      = rsp_bit_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_found_position = rsp_fpos_ff;
   assign rsp_all_equal      = rsp_all_ff;
   assign rsp_bad_position   = rsp_bad_ff;

endmodule

FILE: hw/rtl/bitmap_table_with_find_first_unit.sv
// Top level of the bit table with find-first: register port, sequencer and datapath.
`timescale 1ns / 1ps

// A table of 1024 bits held as 32 words of 32 bits in a single-port memory, bit 0 at the
// most significant bit of word 0, empty after reset with no clearing pass. One request is
// worked at a time; the result waits in an output register so the next request is taken
// while it is pending. A write is a read-modify-write of one word, a fill writes the words
// in use, and test-all and find-first scan the words from their start word onward; the scan
// reads one word per cycle from the memory port. Out-of-range positions, unsupported compare
// values and unknown requests go from decode to the result with no memory access. A result
// that finds the previous one still waiting holds until that one is taken. bit_count is
// written at byte address 0; the user must write it only while the block is idle (not enforced).

module bitmap_table_with_find_first_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bmff_pkg::CODE_W-1:0]   req_type,
   input  logic [bmff_pkg::POS_W-1:0]    req_position,
   input  logic [bmff_pkg::VAL_W-1:0]    req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_bit_value,
   output logic                          rsp_found,
   output logic [bmff_pkg::POS_W-1:0]    rsp_found_position,
   output logic                          rsp_all_equal,
   output logic                          rsp_bad_position,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [bmff_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [bmff_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [bmff_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);

   logic [bmff_pkg::CNT_W-1:0] bit_count;
   bmff_pkg::ctrl_cmd_type     cmd;
   bmff_pkg::dp_status_type    status;

   bmff_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .bit_count   (bit_count)
   );

   bmff_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bmff_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .req_type           (req_type),
      .req_position       (req_position),
      .req_value          (req_value),
      .bit_count          (bit_count),
      .cmd                (cmd),
      .status             (status),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_bit_value      (rsp_bit_value),
      .rsp_found          (rsp_found),
      .rsp_found_position (rsp_found_position),
      .rsp_all_equal      (rsp_all_equal),
      .rsp_bad_position   (rsp_bad_position)
   );

`ifndef ASSERT_OFF
   // one request in flight: a transfer closes the input until the result is queued
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while another is in flight");

   // each result answers exactly one kind of request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_bit_value, rsp_found, rsp_all_equal, rsp_bad_position}))
      else $error("result flags of different requests set together");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_found_position == '0))
      else $error("found position set without a match");
`endif

endmodule

FILE: verif/bitmap_table_with_find_first_unit_tb.sv
// Self-checking testbench for the bit table with find-first: directed and random requests.
`timescale 1ns / 1ps

module bitmap_table_with_find_first_unit_tb;

   import bmff_pkg::*;

   localparam int unsigned            CYCLE_LIMIT       = 400000;
   localparam int unsigned            DRAIN_CYCLES      = 40;
   localparam int unsigned            ITEMS_PER_PHASE   = 48;
   localparam logic [CODE_W-1:0]      REQ_UNKNOWN_FIRST = 3'd5;
   localparam logic [CODE_W-1:0]      REQ_UNKNOWN_LAST  = 3'd7;
   localparam logic [CSR_AW-1:0]      ADDR_BIT_COUNT    = '0;

   typedef struct packed {
      logic             bit_value;
      logic             found;
      logic [POS_W-1:0] found_position;
      logic             all_equal;
      logic             bad_position;
   } table_response_t;

   // shadow copy of the bit table plus the queue of responses it predicts
   class bit_table_scoreboard;
      bit [WORD_BITS-1:0] words [WORD_COUNT];
      bit [CNT_W-1:0]     bit_count;
      table_response_t    pending_responses [$];
      int unsigned        mismatches;

      function new();
         foreach (words[i]) words[i] = '0;
         bit_count   = BIT_COUNT_RESET;
         mismatches  = 0;
      endfunction

      function void set_bit_count(bit [CNT_W-1:0] count);
         bit_count = count;
      endfunction

      function int unsigned used_bits();
         return (bit_count > MAX_BITS) ? MAX_BITS : int'(bit_count);
      endfunction

      function bit bit_at(int unsigned p);
         return (words[p / WORD_BITS] & (TOP_BIT >> (p % WORD_BITS))) != 0;
      endfunction

      function int unsigned pending_count();
         return pending_responses.size();
      endfunction

      function void note_request(logic [CODE_W-1:0] code, logic [POS_W-1:0] pos,
                                 logic [VAL_W-1:0] val);
         table_response_t     rsp;
         int unsigned         n;
         int unsigned         p;
         int unsigned         w;
         bit [WORD_BITS-1:0]  m;
         n   = used_bits();
         p   = pos;
         rsp = '0;
         case (code)
            REQ_READ: begin
               if (p < n) rsp.bit_value = bit_at(p);
               else rsp.bad_position = 1'b1;
            end
            REQ_WRITE: begin
               if (p < n) begin
                  w = p / WORD_BITS;
                  m = TOP_BIT >> (p % WORD_BITS);
                  if (val == 0) words[w] &= ~m;
                  else if (val == 1) words[w] |= m;
                  else words[w] = '0;
               end else begin
                  rsp.bad_position = 1'b1;
               end
            end
            REQ_FILL: begin
               if (val <= 1) begin
                  for (int unsigned i = 0; i < (n + WORD_BITS - 1) / WORD_BITS; i++)
                     words[i] = (val == 1) ? ALL_ONES : '0;
               end
            end
            REQ_TEST: begin
               rsp.all_equal = 1'b1;
               for (int unsigned i = 0; i < n; i++) begin
                  if (val > 1 || bit_at(i) != val[0]) begin
                     rsp.all_equal = 1'b0;
                     break;
                  end
               end
            end
            REQ_FIND: begin
               if (p < n) begin
                  if (val <= 1) begin
                     for (int unsigned i = p; i < n; i++) begin
                        if (bit_at(i) == val[0]) begin
                           rsp.found          = 1'b1;
                           rsp.found_position = POS_W'(i);
                           break;
                        end
                     end
                  end
               end else begin
                  rsp.bad_position = 1'b1;
               end
            end
            default: ;
         endcase
         pending_responses.push_back(rsp);
      endfunction

      function void check_response(table_response_t got);
         table_response_t exp;
         if (pending_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response transfer with nothing pending: bit=%b found=%b pos=%0d all=%b bad=%b",
                        $time, got.bit_value, got.found, got.found_position, got.all_equal,
                        got.bad_position);
            return;
         end
         exp = pending_responses.pop_front();
         if (got.bit_value !== exp.bit_value || got.found !== exp.found ||
             got.found_position !== exp.found_position || got.all_equal !== exp.all_equal ||
             got.bad_position !== exp.bad_position) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: exp bit=%b found=%b pos=%0d all=%b bad=%b / got bit=%b found=%b pos=%0d all=%b bad=%b",
                        $time, exp.bit_value, exp.found, exp.found_position, exp.all_equal,
                        exp.bad_position, got.bit_value, got.found, got.found_position,
                        got.all_equal, got.bad_position);
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [CODE_W-1:0]   req_type = REQ_READ;
   logic [POS_W-1:0]    req_position = '0;
   logic [VAL_W-1:0]    req_value = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_bit_value;
   logic                rsp_found;
   logic [POS_W-1:0]    rsp_found_position;
   logic                rsp_all_equal;
   logic                rsp_bad_position;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [CSR_DW-1:0]   csr_pwdata = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   bit_table_scoreboard sb = new();
   int unsigned         cycles = 0;
   int unsigned         burst_left = 0;
   int unsigned         stall_pct = 0;
   int unsigned         stall_phase_left = 0;

   bitmap_table_with_find_first_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_bit_value      (rsp_bit_value),
      .rsp_found          (rsp_found),
      .rsp_found_position (rsp_found_position),
      .rsp_all_equal      (rsp_all_equal),
      .rsp_bad_position   (rsp_bad_position),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_type, req_position, req_value);
         if (rsp_valid && rsp_ready)
            sb.check_response({rsp_bit_value, rsp_found, rsp_found_position, rsp_all_equal,
                               rsp_bad_position});
      end
   end

   // receiver: stall probability changes from phase to phase
   always @(negedge clock) begin
      if (stall_phase_left == 0) begin
         stall_phase_left = $urandom_range(20, 200);
         case ($urandom_range(0, 2))
            0:       stall_pct = 0;
            1:       stall_pct = 40;
            default: stall_pct = 85;
         endcase
      end
      stall_phase_left--;
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   task automatic send_request(input logic [CODE_W-1:0] code, input logic [POS_W-1:0] pos,
                               input logic [VAL_W-1:0] val);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid    <= 1'b1;
      req_type     <= code;
      req_position <= pos;
      req_value    <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid  <= 1'b0;
      burst_left = 0;
      while (sb.pending_count() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_bit_count(input logic [CNT_W-1:0] count);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_BIT_COUNT;
      csr_pwdata  <= {(CSR_DW - CNT_W)'($urandom()), count};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_bit_count(count);
   endtask

   task automatic send_random(input int unsigned n);
      int unsigned       pick;
      int unsigned       pos;
      logic [CODE_W-1:0] code;
      logic [VAL_W-1:0]  val;
      pick = $urandom_range(0, 99);
      if (pick < 20) code = REQ_READ;
      else if (pick < 50) code = REQ_WRITE;
      else if (pick < 58) code = REQ_FILL;
      else if (pick < 70) code = REQ_TEST;
      else if (pick < 97) code = REQ_FIND;
      else code = CODE_W'($urandom_range(REQ_UNKNOWN_FIRST, REQ_UNKNOWN_LAST));
      pick = $urandom_range(0, 99);
      if (n > 0 && pick < 60) pos = $urandom_range(0, n - 1);
      else if (pick < 75) pos = $urandom_range((n > 2) ? n - 2 : 0, n + 1);
      else pos = $urandom_range(0, MAX_BITS - 1);
      pick = $urandom_range(0, 99);
      if (pick < 45) val = 8'd0;
      else if (pick < 90) val = 8'd1;
      else val = VAL_W'($urandom_range(0, 255));
      send_request(code, POS_W'(pos), val);
   endtask

   initial begin
      int unsigned bit_counts [9];
      int unsigned n;
      bit_counts = '{1024, 0, 2047, 1, 33, 1025, 32, 700, 0};
      bit_counts[8] = $urandom_range(2, 1024);

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // directed pass on the full table after reset
      send_request(REQ_READ,  10'd0,    8'd0);
      send_request(REQ_READ,  10'd1023, 8'd0);
      send_request(REQ_TEST,  10'd0,    8'd0);
      send_request(REQ_FIND,  10'd0,    8'd1);
      send_request(REQ_FIND,  10'd0,    8'd0);
      send_request(REQ_WRITE, 10'd0,    8'd1);
      send_request(REQ_WRITE, 10'd31,   8'd1);
      send_request(REQ_WRITE, 10'd1023, 8'd1);
      send_request(REQ_READ,  10'd0,    8'd0);
      send_request(REQ_READ,  10'd1023, 8'd0);
      send_request(REQ_FIND,  10'd1,    8'd1);
      send_request(REQ_FIND,  10'd32,   8'd1);
      send_request(REQ_WRITE, 10'd5,    8'd255);
      send_request(REQ_READ,  10'd31,   8'd0);
      send_request(REQ_FILL,  10'd0,    8'd7);
      send_request(REQ_FILL,  10'd0,    8'd1);
      send_request(REQ_TEST,  10'd0,    8'd1);
      send_request(REQ_TEST,  10'd0,    8'd2);
      send_request(REQ_FIND,  10'd1023, 8'd0);
      send_request(REQ_FIND,  10'd0,    8'd3);
      send_request(REQ_WRITE, 10'd500,  8'd0);
      send_request(REQ_FIND,  10'd0,    8'd0);
      send_request(REQ_UNKNOWN_FIRST, 10'd1023, 8'd255);
      send_request(3'd6,      10'd512,  8'd128);
      send_request(REQ_UNKNOWN_LAST,  10'd0,    8'd1);

      foreach (bit_counts[ph]) begin
         wait_idle();
         write_bit_count(CNT_W'(bit_counts[ph]));
         n = (bit_counts[ph] > MAX_BITS) ? MAX_BITS : bit_counts[ph];
         repeat (ITEMS_PER_PHASE) send_random(n);
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_count() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/bmff_pkg.sv
hw/rtl/bmff_csr.sv
hw/rtl/bmff_ctrl.sv
hw/rtl/bmff_dpath.sv
hw/rtl/bitmap_table_with_find_first_unit.sv
verif/bitmap_table_with_find_first_unit_tb.sv
